>>> design/gbsf_pkg.sv
`timescale 1ns / 1ps

package gbsf_pkg;

  localparam int VAL_W = 32;
  localparam int POS_W = 12;
  localparam int IMP_W = 25;

  // a split is admissible when m*(n-m) is at least n*n / 20
  localparam int BAL_RATIO = 20;

  typedef struct packed {
    logic signed [VAL_W-1:0] sample_value;
    logic                    class_label;
    logic                    last_sample;
  } in_beat_t;

  typedef struct packed {
    logic             split_found;
    logic [POS_W-1:0] split_position;
    logic [IMP_W-1:0] best_impurity;
    logic             capacity_overflow;
  } out_beat_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             label;
  } sample_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SQN,
    ST_PRIME,
    ST_FETCH,
    ST_STEP,
    ST_BAL,
    ST_MD0,
    ST_DV0,
    ST_W0,
    ST_MN1,
    ST_MD1,
    ST_DV1,
    ST_W1,
    ST_ADV,
    ST_OUT
  } gbsf_state_e;

endpackage

>>> design/gini_best_split_finder.sv
`timescale 1ns / 1ps

// Gini split search over one set of samples sorted ascending by value.
// Input channel: in_valid_i / in_stall_o carry one sample per beat (value, class label,
// last flag). The block takes samples one per cycle while loading; the beat with
// last_sample set closes the set, and in_stall_o then stays high until the search ends.
// Samples past MAX_SAMPLES are dropped and reported through capacity_overflow.
// Output channel: out_valid_o / out_stall_i carry one result beat per set, held in an
// output register; the next set may load while that beat waits. A receiver that stalls
// only holds back the end of the following search.
// After the last sample, a set of fewer than two samples goes straight to the result;
// otherwise each split position is read in turn. A position whose value repeats the one
// before is skipped, one that is too unbalanced is dropped, and every other one is scored.
// The scored positions dominate: each needs two divisions through one shared bit-serial
// divider, and five products through one shared multiplier.
// Reset clears the sample count, the class-0 total, the overflow flag and the output
// valid; the sample store itself holds no reset state and only entries written in the
// current set are read.
module gini_best_split_finder #(
  parameter int MAX_SAMPLES = 4096,
  parameter int FRAC_BITS   = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gbsf_pkg::in_beat_t  in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gbsf_pkg::out_beat_t out_o
);

  localparam int AW    = $clog2(MAX_SAMPLES);
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int PW    = 2 * CNT_W;
  localparam int BAL_W = PW + 5;
  localparam int QW    = FRAC_BITS - 1;
  localparam int BW    = FRAC_BITS + 1;
  localparam int PXW   = (CNT_W > gbsf_pkg::POS_W) ? CNT_W : gbsf_pkg::POS_W;
  localparam int IXW   = (BW > gbsf_pkg::IMP_W) ? BW : gbsf_pkg::IMP_W;
  localparam logic [BW-1:0] ONE = BW'(1) << FRAC_BITS;

  gbsf_pkg::gbsf_state_e state_q, state_d;

  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [CNT_W-1:0]          ztot_q, ztot_d;
  logic                      ovf_q, ovf_d;
  logic [CNT_W-1:0]          m_q, m_d;
  logic [CNT_W-1:0]          zlow_q, zlow_d;
  logic [gbsf_pkg::VAL_W-1:0] prev_val_q, prev_val_d;
  logic                      prev_lab_q, prev_lab_d;
  logic [PW-1:0]             prod_q, prod_d;
  logic [PW-1:0]             num_q, num_d;
  logic [PW-1:0]             nn_q, nn_d;
  logic [QW-1:0]             q0_q, q0_d;
  logic [BW-1:0]             best_q, best_d;
  logic [CNT_W-1:0]          pos_q, pos_d;
  logic                      found_q, found_d;
  logic                      out_valid_q, out_valid_d;
  gbsf_pkg::out_beat_t       out_q, out_d;

  logic                      in_accept;
  logic                      st_we;
  logic [AW-1:0]             st_raddr;
  gbsf_pkg::sample_t         st_wdata, st_rdata;
  logic [CNT_W-1:0]          mul_a, mul_b;
  logic [PW-1:0]             mul_p;
  logic [CNT_W-1:0]          up, zup;
  logic [BAL_W-1:0]          bal;
  logic                      div_start, div_done;
  logic [QW-1:0]             div_quo;
  logic [BW-1:0]             imp;
  logic [PXW-1:0]            pos_x;
  logic [IXW-1:0]            best_x;

  assign in_stall_o = (state_q != gbsf_pkg::ST_LOAD);
  assign in_accept  = in_valid_i && (state_q == gbsf_pkg::ST_LOAD);

  assign st_wdata.value = in_i.sample_value;
  assign st_wdata.label = in_i.class_label;

  gbsf_sample_store #(
    .DEPTH (MAX_SAMPLES),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  gbsf_divider #(
    .PROD_W    (PW),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .prod_i  (num_q),
    .den_i   (prod_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign up    = cnt_q - m_q;
  assign zup   = ztot_q - zlow_q;
  assign mul_p = mul_a * mul_b;
  assign bal   = BAL_W'(prod_q) * BAL_W'(gbsf_pkg::BAL_RATIO);
  assign imp   = BW'(q0_q) + BW'(div_quo);
  assign pos_x  = PXW'(pos_q);
  assign best_x = IXW'(best_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ztot_d      = ztot_q;
    ovf_d       = ovf_q;
    m_d         = m_q;
    zlow_d      = zlow_q;
    prev_val_d  = prev_val_q;
    prev_lab_d  = prev_lab_q;
    prod_d      = prod_q;
    num_d       = num_q;
    nn_d        = nn_q;
    q0_d        = q0_q;
    best_d      = best_q;
    pos_d       = pos_q;
    found_d     = found_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    st_we       = 1'b0;
    st_raddr    = '0;
    mul_a       = m_q;
    mul_b       = up;
    div_start   = 1'b0;

    case (state_q)
      gbsf_pkg::ST_LOAD: begin
        if (in_accept) begin
          if (cnt_q < CNT_W'(MAX_SAMPLES)) begin
            st_we = 1'b1;
            cnt_d = cnt_q + 1'b1;
            if (!in_i.class_label) begin
              ztot_d = ztot_q + 1'b1;
            end
          end else begin
            ovf_d = 1'b1;
          end
          if (in_i.last_sample) begin
            state_d = gbsf_pkg::ST_SQN;
          end
        end
      end
      gbsf_pkg::ST_SQN: begin
        // n*n for the balance test; entry 0 is read meanwhile
        mul_a   = cnt_q;
        mul_b   = cnt_q;
        prod_d  = mul_p;
        best_d  = ONE;
        pos_d   = '0;
        found_d = 1'b0;
        state_d = (cnt_q < CNT_W'(2)) ? gbsf_pkg::ST_OUT : gbsf_pkg::ST_PRIME;
      end
      gbsf_pkg::ST_PRIME: begin
        nn_d       = prod_q;
        prev_val_d = st_rdata.value;
        prev_lab_d = st_rdata.label;
        m_d        = CNT_W'(1);
        zlow_d     = '0;
        state_d    = gbsf_pkg::ST_FETCH;
      end
      gbsf_pkg::ST_FETCH: begin
        st_raddr = m_q[AW-1:0];
        state_d  = gbsf_pkg::ST_STEP;
      end
      gbsf_pkg::ST_STEP: begin
        zlow_d     = zlow_q + CNT_W'(!prev_lab_q);
        prev_val_d = st_rdata.value;
        prev_lab_d = st_rdata.label;
        prod_d     = mul_p;
        state_d    = (st_rdata.value == prev_val_q) ? gbsf_pkg::ST_ADV : gbsf_pkg::ST_BAL;
      end
      gbsf_pkg::ST_BAL: begin
        mul_a  = zlow_q;
        mul_b  = m_q - zlow_q;
        prod_d = mul_p;
        state_d = (bal < BAL_W'(nn_q)) ? gbsf_pkg::ST_ADV : gbsf_pkg::ST_MD0;
      end
      gbsf_pkg::ST_MD0: begin
        num_d   = prod_q;
        mul_a   = m_q;
        mul_b   = m_q;
        prod_d  = mul_p;
        state_d = gbsf_pkg::ST_DV0;
      end
      gbsf_pkg::ST_DV0: begin
        div_start = 1'b1;
        state_d   = gbsf_pkg::ST_W0;
      end
      gbsf_pkg::ST_W0: begin
        if (div_done) begin
          q0_d    = div_quo;
          state_d = gbsf_pkg::ST_MN1;
        end
      end
      gbsf_pkg::ST_MN1: begin
        mul_a   = zup;
        mul_b   = up - zup;
        prod_d  = mul_p;
        state_d = gbsf_pkg::ST_MD1;
      end
      gbsf_pkg::ST_MD1: begin
        num_d   = prod_q;
        mul_a   = up;
        mul_b   = up;
        prod_d  = mul_p;
        state_d = gbsf_pkg::ST_DV1;
      end
      gbsf_pkg::ST_DV1: begin
        div_start = 1'b1;
        state_d   = gbsf_pkg::ST_W1;
      end
      gbsf_pkg::ST_W1: begin
        if (div_done) begin
          // strict compare keeps the first minimum
          if (imp < best_q) begin
            best_d  = imp;
            pos_d   = m_q;
            found_d = 1'b1;
          end
          state_d = gbsf_pkg::ST_ADV;
        end
      end
      gbsf_pkg::ST_ADV: begin
        if (m_q == cnt_q - 1'b1) begin
          state_d = gbsf_pkg::ST_OUT;
        end else begin
          m_d     = m_q + 1'b1;
          state_d = gbsf_pkg::ST_FETCH;
        end
      end
      gbsf_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d             = 1'b1;
          out_d.split_found       = found_q;
          out_d.split_position    = pos_x[gbsf_pkg::POS_W-1:0];
          out_d.best_impurity     = best_x[gbsf_pkg::IMP_W-1:0];
          out_d.capacity_overflow = ovf_q;
          cnt_d                   = '0;
          ztot_d                  = '0;
          ovf_d                   = 1'b0;
          state_d                 = gbsf_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = gbsf_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gbsf_pkg::ST_LOAD;
      cnt_q       <= '0;
      ztot_q      <= '0;
      ovf_q       <= 1'b0;
      m_q         <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ztot_q      <= ztot_d;
      ovf_q       <= ovf_d;
      m_q         <= m_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zlow_q     <= zlow_d;
    prev_val_q <= prev_val_d;
    prev_lab_q <= prev_lab_d;
    prod_q     <= prod_d;
    num_q      <= num_d;
    nn_q       <= nn_d;
    q0_q       <= q0_d;
    best_q     <= best_d;
    pos_q      <= pos_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_out_from_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == gbsf_pkg::ST_OUT))
    else $error("result beat raised outside the final state");

  a_found_below_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gbsf_pkg::ST_ADV) && found_q |-> (best_q < ONE))
    else $error("split found with impurity not below one");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gbsf_pkg::ST_ADV) && found_q |-> (pos_q != '0) && (pos_q <= m_q))
    else $error("best position outside the scanned range");

  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_SAMPLES))
    else $error("sample count beyond store depth");

  a_div_done_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == gbsf_pkg::ST_W0) || (state_q == gbsf_pkg::ST_W1))
    else $error("divider finished while no division was pending");

endmodule

>>> design/gbsf_sample_store.sv
`timescale 1ns / 1ps

module gbsf_sample_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  gbsf_pkg::sample_t wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output gbsf_pkg::sample_t rdata_o
);

  gbsf_pkg::sample_t mem_q [DEPTH];
  gbsf_pkg::sample_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/gbsf_divider.sv
`timescale 1ns / 1ps

// restoring divider for floor((prod << FRAC_BITS) / den), one quotient bit a cycle;
// the caller guarantees the quotient is below 2^(FRAC_BITS-1)
module gbsf_divider #(
  parameter int PROD_W    = 26,
  parameter int FRAC_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [PROD_W-1:0]    prod_i,
  input  logic [PROD_W-1:0]    den_i,
  output logic                 done_o,
  output logic [FRAC_BITS-2:0] quo_o
);

  localparam int QW = FRAC_BITS - 1;
  localparam int CW = $clog2(QW + 1);

  logic [PROD_W:0]     rem_q, rem_d;
  logic [PROD_W-1:0]   den_q, den_d;
  logic [QW-1:0]       quo_q, quo_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [PROD_W+1:0]   trial;
  logic                ge;

  always_comb begin
    trial  = {rem_q, 1'b0};
    ge     = trial >= (PROD_W+2)'(den_q);
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      // the low FRAC_BITS-1 numerator bits are zero, only the top part is loaded
      rem_d  = {prod_i, 1'b0};
      den_d  = den_i;
      quo_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? (PROD_W+1)'(trial - (PROD_W+2)'(den_q)) : (PROD_W+1)'(trial);
      quo_d = {quo_q[QW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(QW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
